@@ rtl/core/psieve_pkg.sv @@
package psieve_pkg;

  localparam int unsigned PS_TABLE_SIZE = 4096;
  localparam int unsigned VAL_W         = 12;
  localparam int unsigned ST_W          = 2;
  localparam int unsigned IDX_W         = 7;    // sieve index, i*i stays within a 12-bit limit
  localparam int unsigned CNT_W         = 13;   // walk counter and square, one above the limit

  localparam logic [VAL_W-1:0] LIMIT_RESET = 12'hFFF;

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_ABOVE   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNBUILT = 2'd2;

  typedef struct packed {
    logic we;
    logic wbit;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic            is_prime;
    logic [ST_W-1:0] status;
  } res_t;

endpackage

@@ rtl/core/psieve_if.sv @@
interface psieve_in_if import psieve_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [VAL_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface psieve_out_if import psieve_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            is_prime;
  logic [ST_W-1:0] status;

  modport source (output valid, output is_prime, output status, input ready);
  modport sink (input valid, input is_prime, input status, output ready);
endinterface

interface psieve_cfg_if import psieve_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/psieve_mem.sv @@
module psieve_mem import psieve_pkg::*; #(
  parameter int unsigned TABLE_SIZE = PS_TABLE_SIZE,
  localparam int unsigned AW = $clog2(TABLE_SIZE)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [TABLE_SIZE];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wbit;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/psieve_ctrl.sv @@
module psieve_ctrl import psieve_pkg::*; #(
  parameter int unsigned TABLE_SIZE = PS_TABLE_SIZE,
  localparam int unsigned AW = $clog2(TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [VAL_W-1:0] in_value,
  input  logic [VAL_W-1:0] limit,
  output mem_ctl_t         ctl,
  output logic [AW-1:0]    waddr,
  output logic [AW-1:0]    raddr,
  input  logic             rdata,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QWAIT = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic             built_r, built_nxt;
  logic [VAL_W-1:0] blim_r, blim_nxt;
  logic [VAL_W-1:0] lim_r, lim_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] sq_r, sq_nxt;
  res_t             res_r, res_nxt;
  logic [VAL_W-1:0] lim_clamp;
  logic [CNT_W-1:0] j_step;
  logic [CNT_W-1:0] sq_step;

  assign lim_clamp = (32'(limit) > TABLE_SIZE - 1) ? VAL_W'(TABLE_SIZE - 1) : limit;
  assign j_step    = j_r + CNT_W'(i_r);
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_step   = sq_r + CNT_W'({i_r, 1'b1});

  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    blim_nxt  = blim_r;
    lim_nxt   = lim_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sq_nxt    = sq_r;
    res_nxt   = res_r;
    ctl       = '0;
    raddr     = AW'(in_value);
    waddr     = AW'(j_r);
    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_EMIT);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_BUILD) begin
            lim_nxt   = lim_clamp;
            j_nxt     = '0;
            state_nxt = S_FILL;
          end else if (!built_r) begin
            res_nxt   = '{is_prime: 1'b0, status: ST_UNBUILT};
            state_nxt = S_EMIT;
          end else if (in_value > blim_r) begin
            res_nxt   = '{is_prime: 1'b0, status: ST_ABOVE};
            state_nxt = S_EMIT;
          end else begin
            ctl.re    = 1'b1;
            state_nxt = S_QWAIT;
          end
        end
      end
      S_QWAIT: begin
        res_nxt   = '{is_prime: rdata, status: ST_OK};
        state_nxt = S_EMIT;
      end
      S_FILL: begin
        // mark all as prime except 0 and 1
        ctl.we   = 1'b1;
        ctl.wbit = (j_r >= CNT_W'(2));
        if (j_r == CNT_W'(lim_r)) begin
          i_nxt     = IDX_W'(2);
          sq_nxt    = CNT_W'(4);
          state_nxt = S_RD;
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end
      S_RD: begin
        if (sq_r > CNT_W'(lim_r)) begin
          built_nxt = 1'b1;
          blim_nxt  = lim_r;
          res_nxt   = '{is_prime: 1'b0, status: ST_OK};
          state_nxt = S_EMIT;
        end else begin
          ctl.re    = 1'b1;
          raddr     = AW'(i_r);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (rdata) begin
          j_nxt     = sq_r;
          state_nxt = S_MARK;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          sq_nxt    = sq_step;
          state_nxt = S_RD;
        end
      end
      S_MARK: begin
        ctl.we   = 1'b1;
        ctl.wbit = 1'b0;
        if (j_step > CNT_W'(lim_r)) begin
          i_nxt     = i_r + IDX_W'(1);
          sq_nxt    = sq_step;
          state_nxt = S_RD;
        end else begin
          j_nxt = j_step;
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
      blim_r  <= '0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      blim_r  <= blim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

  a_unbuilt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_QUERY && !built_r
    |=> res_valid && res.status == ST_UNBUILT && !res.is_prime)
    else $error("query before build not flagged");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.we |-> j_r <= CNT_W'(lim_r))
    else $error("table write beyond build limit");

  a_set_only_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.we && ctl.wbit |-> state_r == S_FILL)
    else $error("prime bit set outside fill pass");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> in_ready && !res_valid)
    else $error("no return to idle after result handoff");

endmodule

@@ rtl/core/prime_sieve_table_top.sv @@
// Query: the table read is registered, then the result is registered (S_QWAIT, S_EMIT);
//   a query flagged as unbuilt or above limit goes straight to S_EMIT. A new item is
//   taken only after the result leaves S_EMIT. Build: a fill pass, then a mark pass per
//   prime p, p*p <= limit; these passes write once per cycle through the single write port.
// One item at a time; one result may wait at the output while the next item is taken.
// Reset (rst_n low, synchronous): no table built, limit = 4095, output empty.
module prime_sieve_table_top import psieve_pkg::*; #(
  parameter int unsigned TABLE_SIZE = PS_TABLE_SIZE
) (
  input logic         clk,
  input logic         rst_n,
  psieve_in_if.sink   in_ch,
  psieve_out_if.source out_ch,
  psieve_cfg_if.sink  cfg_ch
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  logic [VAL_W-1:0] limit_r;
  mem_ctl_t         ctl;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic             rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_r;
  res_t             out_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      limit_r <= cfg_ch.data;
    end
  end

  psieve_ctrl #(.TABLE_SIZE(TABLE_SIZE)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_mode  (in_ch.mode),
    .in_value (in_ch.value),
    .limit    (limit_r),
    .ctl      (ctl),
    .waddr    (waddr),
    .raddr    (raddr),
    .rdata    (rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  psieve_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem (
    .clk  (clk),
    .ctl  (ctl),
    .waddr(waddr),
    .raddr(raddr),
    .rdata(rdata)
  );

  // output register: load when empty or draining
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_prime = out_r.is_prime;
  assign out_ch.status   = out_r.status;

endmodule
